// ===== sv/lsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, operation codes and helpers of the logic and shift unit.
package lsu_pkg;

   typedef enum logic [3:0] {
      FUNC_TEST  = 4'd0,
      FUNC_AND   = 4'd1,
      FUNC_XOR   = 4'd2,
      FUNC_OR    = 4'd3,
      FUNC_SAR   = 4'd4,
      FUNC_SHL   = 4'd5,
      FUNC_SHR   = 4'd6,
      FUNC_SETCC = 4'd7,
      FUNC_NOT   = 4'd8
   } func_type;

   localparam logic [1:0] WIDTH_BYTE  = 2'd0;
   localparam logic [1:0] WIDTH_WORD  = 2'd1;
   localparam logic [1:0] WIDTH_DWORD = 2'd2;

   localparam logic [2:0] CC_O  = 3'd0;
   localparam logic [2:0] CC_B  = 3'd1;
   localparam logic [2:0] CC_E  = 3'd2;
   localparam logic [2:0] CC_BE = 3'd3;
   localparam logic [2:0] CC_S  = 3'd4;
   localparam logic [2:0] CC_P  = 3'd5;
   localparam logic [2:0] CC_L  = 3'd6;
   localparam logic [2:0] CC_LE = 3'd7;

   localparam int SETCC_KEEP_SHIFT = 8;

   typedef struct packed {
      logic [3:0]  func;
      logic [1:0]  width_code;
      logic [31:0] dest;
      logic [31:0] src;
      logic [31:0] dest_ext;
      logic [4:0]  count;
      logic        cond_true;
      logic        cf;
      logic        of;
      logic        zf;
      logic        sf;
   } dec_type;

   typedef struct packed {
      logic [1:0]  width_code;
      logic [31:0] result;
      logic        write_back;
      logic        set_zf_sf;
      logic        cf;
      logic        of;
      logic        zf;
      logic        sf;
   } exe_type;

   typedef struct packed {
      logic [31:0] result;
      logic        write_back;
      logic        cf;
      logic        of;
      logic        zf;
      logic        sf;
   } rsp_type;

   function automatic logic [31:0] width_mask(input logic [1:0] wc);
      logic [31:0] m;
      case (wc)
         WIDTH_BYTE: m = 32'h0000_00ff;
         WIDTH_WORD: m = 32'h0000_ffff;
         default:    m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

// ===== sv/lsu_decode.sv =====
`timescale 1ns / 1ps
// First stage: operand masking, sign extension and condition evaluation.
module lsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [3:0]         func,
   input  logic [31:0]        dest_value,
   input  logic [31:0]        src_value,
   input  logic [1:0]         width_code,
   input  logic [3:0]         cond_code,
   input  logic               cf_in,
   input  logic               of_in,
   input  logic               zf_in,
   input  logic               sf_in,
   input  logic               pf_in,
   output logic               out_valid,
   output lsu_pkg::dec_type   out_data
);

   logic              valid_ff;
   logic              valid_in;
   lsu_pkg::dec_type  data_ff;
   lsu_pkg::dec_type  data_in;
   logic [31:0]       mask;
   logic [31:0]       dest_masked;
   logic              sign;
   logic              cond_base;

   always_comb begin
      mask        = lsu_pkg::width_mask(width_code);
      dest_masked = dest_value & mask;
      case (width_code)
         lsu_pkg::WIDTH_BYTE: sign = dest_value[7];
         lsu_pkg::WIDTH_WORD: sign = dest_value[15];
         default:             sign = dest_value[31];
      endcase
      case (cond_code[3:1])
         lsu_pkg::CC_O:  cond_base = of_in;
         lsu_pkg::CC_B:  cond_base = cf_in;
         lsu_pkg::CC_E:  cond_base = zf_in;
         lsu_pkg::CC_BE: cond_base = cf_in | zf_in;
         lsu_pkg::CC_S:  cond_base = sf_in;
         lsu_pkg::CC_P:  cond_base = pf_in;
         lsu_pkg::CC_L:  cond_base = sf_in ^ of_in;
         default:        cond_base = zf_in | (sf_in ^ of_in);
      endcase
      data_in.func       = func;
      data_in.width_code = width_code;
      data_in.dest       = dest_masked;
      data_in.src        = src_value & mask;
      data_in.dest_ext   = sign ? (dest_masked | ~mask) : dest_masked;
      data_in.count      = src_value[4:0];
      data_in.cond_true  = cond_base ^ cond_code[0];
      data_in.cf         = cf_in;
      data_in.of         = of_in;
      data_in.zf         = zf_in;
      data_in.sf         = sf_in;
      valid_in           = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/lsu_execute.sv =====
`timescale 1ns / 1ps
// Second stage: logic operations, barrel shifter and result selection.
module lsu_execute (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  lsu_pkg::dec_type   in_data,
   output logic               out_valid,
   output lsu_pkg::exe_type   out_data
);

   logic              valid_ff;
   lsu_pkg::exe_type  data_ff;
   lsu_pkg::exe_type  data_in;
   logic [31:0]       raw;

   always_comb begin
      raw                = in_data.dest;
      data_in.write_back = 1'b1;
      data_in.set_zf_sf  = 1'b0;
      data_in.cf         = in_data.cf;
      data_in.of         = in_data.of;
      data_in.zf         = in_data.zf;
      data_in.sf         = in_data.sf;
      case (in_data.func)
         lsu_pkg::FUNC_TEST: begin
            raw                = in_data.dest & in_data.src;
            data_in.write_back = 1'b0;
            data_in.cf         = 1'b0;
            data_in.of         = 1'b0;
            data_in.set_zf_sf  = 1'b1;
         end
         lsu_pkg::FUNC_AND: begin
            raw               = in_data.dest & in_data.src;
            data_in.cf        = 1'b0;
            data_in.of        = 1'b0;
            data_in.set_zf_sf = 1'b1;
         end
         lsu_pkg::FUNC_XOR: begin
            raw               = in_data.dest ^ in_data.src;
            data_in.cf        = 1'b0;
            data_in.of        = 1'b0;
            data_in.set_zf_sf = 1'b1;
         end
         lsu_pkg::FUNC_OR: begin
            raw               = in_data.dest | in_data.src;
            data_in.cf        = 1'b0;
            data_in.of        = 1'b0;
            data_in.set_zf_sf = 1'b1;
         end
         lsu_pkg::FUNC_SAR: begin
            raw               = $unsigned($signed(in_data.dest_ext) >>> in_data.count);
            data_in.set_zf_sf = 1'b1;
         end
         lsu_pkg::FUNC_SHL: begin
            raw               = in_data.dest << in_data.count;
            data_in.set_zf_sf = 1'b1;
         end
         lsu_pkg::FUNC_SHR: begin
            raw               = in_data.dest >> in_data.count;
            data_in.set_zf_sf = 1'b1;
         end
         lsu_pkg::FUNC_SETCC: begin
            raw = {in_data.dest[31:lsu_pkg::SETCC_KEEP_SHIFT],
                   {(lsu_pkg::SETCC_KEEP_SHIFT - 1){1'b0}}, in_data.cond_true};
         end
         lsu_pkg::FUNC_NOT: begin
            raw = ~in_data.dest;
         end
         default: begin
            raw                = in_data.dest;
            data_in.write_back = 1'b0;
         end
      endcase
      data_in.result     = raw & lsu_pkg::width_mask(in_data.width_code);
      data_in.width_code = in_data.width_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/lsu_flags.sv =====
`timescale 1ns / 1ps
// Third stage: zero and sign flag generation and the output register.
module lsu_flags (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  lsu_pkg::exe_type   in_data,
   output logic               out_valid,
   output lsu_pkg::rsp_type   out_data
);

   logic              valid_ff;
   lsu_pkg::rsp_type  data_ff;
   lsu_pkg::rsp_type  data_in;
   logic              sign;

   always_comb begin
      case (in_data.width_code)
         lsu_pkg::WIDTH_BYTE: sign = in_data.result[7];
         lsu_pkg::WIDTH_WORD: sign = in_data.result[15];
         default:             sign = in_data.result[31];
      endcase
      data_in.result     = in_data.result;
      data_in.write_back = in_data.write_back;
      data_in.cf         = in_data.cf;
      data_in.of         = in_data.of;
      data_in.zf         = in_data.set_zf_sf ? (in_data.result == 32'd0) : in_data.zf;
      data_in.sf         = in_data.set_zf_sf ? sign : in_data.sf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/x86_logic_shift_unit_top.sv =====
`timescale 1ns / 1ps
// Top level of the x86 logic and shift unit: three-stage execute pipeline.
//
// The req_ channel carries one instruction per beat: function, operands, width,
// condition code and the current flags. The rsp_ channel returns one beat per
// instruction with the truncated result, the write-back enable and new flags.
// Both channels use a valid/ready handshake.
// The pipeline has three register stages: operand decode, logic and barrel
// shift, then flag generation into the output register. A beat accepted
// into the decode register moves on to the execute register and then to the
// flags register, from which it is offered on rsp_.
// One beat is accepted per cycle while req_ready is high; the sustained rate
// is one instruction per clock cycle while the receiver keeps rsp_ready high.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
// Reset, synchronous and active high, empties all stages; the block takes a
// beat in the first cycle after reset is released.
module x86_logic_shift_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_func,
   input  logic [31:0] req_dest_value,
   input  logic [31:0] req_src_value,
   input  logic [1:0]  req_width_code,
   input  logic [3:0]  req_cond_code,
   input  logic        req_cf_in,
   input  logic        req_of_in,
   input  logic        req_zf_in,
   input  logic        req_sf_in,
   input  logic        req_pf_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result,
   output logic        rsp_write_back,
   output logic        rsp_cf_out,
   output logic        rsp_of_out,
   output logic        rsp_zf_out,
   output logic        rsp_sf_out
);

   logic              advance;
   logic              dec_valid;
   lsu_pkg::dec_type  dec_data;
   logic              exe_valid;
   lsu_pkg::exe_type  exe_data;
   logic              out_valid;
   lsu_pkg::rsp_type  out_data;

   assign advance   = !out_valid || rsp_ready;
   assign req_ready = advance;

   lsu_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .func       (req_func),
      .dest_value (req_dest_value),
      .src_value  (req_src_value),
      .width_code (req_width_code),
      .cond_code  (req_cond_code),
      .cf_in      (req_cf_in),
      .of_in      (req_of_in),
      .zf_in      (req_zf_in),
      .sf_in      (req_sf_in),
      .pf_in      (req_pf_in),
      .out_valid  (dec_valid),
      .out_data   (dec_data)
   );

   lsu_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_data  (exe_data)
   );

   lsu_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (exe_valid),
      .in_data   (exe_data),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_valid      = out_valid;
   assign rsp_result     = out_data.result;
   assign rsp_write_back = out_data.write_back;
   assign rsp_cf_out     = out_data.cf;
   assign rsp_of_out     = out_data.of;
   assign rsp_zf_out     = out_data.zf;
   assign rsp_sf_out     = out_data.sf;

endmodule
